// ===== hdl/plcur_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plcur_pkg
// Shared types and constants of the playlist list with cursor block.
// ----------------------------------------------------------------------------
package plcur_pkg;

  localparam int NODES_DEF = 64;
  localparam int OP_W      = 3;
  localparam int VAL_W     = 32;

  typedef enum logic [OP_W-1:0] {
    OP_APPEND = 3'd0,
    OP_READ   = 3'd1,
    OP_NEXT   = 3'd2,
    OP_PREV   = 3'd3,
    OP_PLAY   = 3'd4
  } op_e;

  // Datapath micro-operations, one per cycle.
  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_FULL,
    CMD_APPEND,
    CMD_APP_TAIL,
    CMD_RD_CUR,
    CMD_STEP_SEL,
    CMD_STEP_SET,
    CMD_SRCH_START,
    CMD_SRCH_NEXT,
    CMD_FOUND,
    CMD_UNLINK,
    CMD_INS_RD,
    CMD_LINK1,
    CMD_LINK2,
    CMD_RESP
  } cmd_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_APP,
    ST_APP_TAIL,
    ST_STEP_RD,
    ST_STEP_SEL,
    ST_STEP_SET,
    ST_SRCH_ST,
    ST_SRCH,
    ST_MOVE,
    ST_INS,
    ST_LINK1,
    ST_LINK2,
    ST_RESP
  } state_e;

  typedef struct packed {
    op_e  op;
    logic head_null;
    logic cur_null;
    logic full;
    logic rd_match;
    logic rd_next_null;
    logic link_null;
    logic skip;
    logic out_free;
  } dp_flags_t;

endpackage

// ===== hdl/plcur_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plcur_ctrl
// Sequencer: walks each request through datapath micro-operations.
// ----------------------------------------------------------------------------
module plcur_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  plcur_pkg::dp_flags_t  flags_i,
  output plcur_pkg::cmd_e       cmd_o
);

  plcur_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= plcur_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = plcur_pkg::CMD_NONE;
    in_stall_o = 1'b1;
    case (state_q)
      plcur_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o   = plcur_pkg::CMD_LOAD;
          state_d = plcur_pkg::ST_DISPATCH;
        end
      end
      plcur_pkg::ST_DISPATCH: begin
        case (flags_i.op)
          plcur_pkg::OP_APPEND: state_d = plcur_pkg::ST_APP;
          plcur_pkg::OP_NEXT,
          plcur_pkg::OP_PREV: begin
            state_d = flags_i.cur_null ? plcur_pkg::ST_RESP : plcur_pkg::ST_STEP_RD;
          end
          plcur_pkg::OP_PLAY: begin
            // empty list: play-next behaves as append
            state_d = flags_i.cur_null ? plcur_pkg::ST_APP : plcur_pkg::ST_SRCH_ST;
          end
          default: state_d = plcur_pkg::ST_RESP;
        endcase
      end
      plcur_pkg::ST_APP: begin
        if (flags_i.full) begin
          cmd_o   = plcur_pkg::CMD_FULL;
          state_d = plcur_pkg::ST_RESP;
        end else begin
          cmd_o   = plcur_pkg::CMD_APPEND;
          state_d = flags_i.head_null ? plcur_pkg::ST_RESP : plcur_pkg::ST_APP_TAIL;
        end
      end
      plcur_pkg::ST_APP_TAIL: begin
        cmd_o   = plcur_pkg::CMD_APP_TAIL;
        state_d = plcur_pkg::ST_RESP;
      end
      plcur_pkg::ST_STEP_RD: begin
        cmd_o   = plcur_pkg::CMD_RD_CUR;
        state_d = plcur_pkg::ST_STEP_SEL;
      end
      plcur_pkg::ST_STEP_SEL: begin
        if (flags_i.link_null) begin
          state_d = plcur_pkg::ST_RESP;
        end else begin
          cmd_o   = plcur_pkg::CMD_STEP_SEL;
          state_d = plcur_pkg::ST_STEP_SET;
        end
      end
      plcur_pkg::ST_STEP_SET: begin
        cmd_o   = plcur_pkg::CMD_STEP_SET;
        state_d = plcur_pkg::ST_RESP;
      end
      plcur_pkg::ST_SRCH_ST: begin
        cmd_o   = plcur_pkg::CMD_SRCH_START;
        state_d = plcur_pkg::ST_SRCH;
      end
      plcur_pkg::ST_SRCH: begin
        if (flags_i.rd_match) begin
          cmd_o   = plcur_pkg::CMD_FOUND;
          state_d = plcur_pkg::ST_MOVE;
        end else if (flags_i.rd_next_null) begin
          state_d = plcur_pkg::ST_INS;
        end else begin
          cmd_o = plcur_pkg::CMD_SRCH_NEXT;
        end
      end
      plcur_pkg::ST_MOVE: begin
        if (flags_i.skip) begin
          state_d = plcur_pkg::ST_RESP;
        end else begin
          cmd_o   = plcur_pkg::CMD_UNLINK;
          state_d = plcur_pkg::ST_LINK1;
        end
      end
      plcur_pkg::ST_INS: begin
        if (flags_i.full) begin
          cmd_o   = plcur_pkg::CMD_FULL;
          state_d = plcur_pkg::ST_RESP;
        end else begin
          cmd_o   = plcur_pkg::CMD_INS_RD;
          state_d = plcur_pkg::ST_LINK1;
        end
      end
      plcur_pkg::ST_LINK1: begin
        cmd_o   = plcur_pkg::CMD_LINK1;
        state_d = plcur_pkg::ST_LINK2;
      end
      plcur_pkg::ST_LINK2: begin
        cmd_o   = plcur_pkg::CMD_LINK2;
        state_d = plcur_pkg::ST_RESP;
      end
      plcur_pkg::ST_RESP: begin
        if (flags_i.out_free) begin
          cmd_o   = plcur_pkg::CMD_RESP;
          state_d = plcur_pkg::ST_IDLE;
        end
      end
      default: state_d = plcur_pkg::ST_IDLE;
    endcase
  end

endmodule

// ===== hdl/plcur_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plcur_dp
// Node pool memories, list pointers, scratch registers and result register.
// ----------------------------------------------------------------------------
module plcur_dp #(
  parameter int NODES = plcur_pkg::NODES_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic [plcur_pkg::OP_W-1:0]         operation_i,
  input  logic signed [plcur_pkg::VAL_W-1:0] value_i,
  input  plcur_pkg::cmd_e                    cmd_i,
  output plcur_pkg::dp_flags_t               flags_o,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic signed [plcur_pkg::VAL_W-1:0] current_value_o,
  output logic                               has_current_o,
  output logic                               status_o
);

  localparam int IW = $clog2(NODES + 1);
  localparam int AW = $clog2(NODES);
  localparam logic [IW-1:0] NIL = IW'(NODES);

  // pool memories
  logic signed [plcur_pkg::VAL_W-1:0] mem_val  [NODES];
  logic [IW-1:0]                      mem_next [NODES];
  logic [IW-1:0]                      mem_prev [NODES];

  logic signed [plcur_pkg::VAL_W-1:0] rd_val_q;
  logic [IW-1:0]                      rd_next_q, rd_prev_q;

  // control registers
  logic [IW-1:0] head_q, head_d, tail_q, tail_d, cur_q, cur_d, used_q, used_d;
  logic          out_valid_q, out_valid_d;

  // payload registers
  logic [plcur_pkg::OP_W-1:0]         op_q, op_d;
  logic signed [plcur_pkg::VAL_W-1:0] val_q, val_d, curval_q, curval_d;
  logic [IW-1:0]                      walk_q, walk_d, f_q, f_d, p_q, p_d;
  logic [IW-1:0]                      q_q, q_d, aux_q, aux_d;
  logic                               new_q, new_d, stat_q, stat_d;
  logic signed [plcur_pkg::VAL_W-1:0] out_val_q, out_val_d;
  logic                               out_has_q, out_has_d, out_stat_q, out_stat_d;

  // memory ports
  logic                               rd_en;
  logic [IW-1:0]                      rd_addr;
  logic                               val_we, next_we, prev_we;
  logic [IW-1:0]                      val_wa, next_wa, prev_wa;
  logic signed [plcur_pkg::VAL_W-1:0] val_wd;
  logic [IW-1:0]                      next_wd, prev_wd;

  logic [IW-1:0] link;

  assign link = (op_q == plcur_pkg::OP_NEXT) ? rd_next_q : rd_prev_q;

  assign flags_o.op           = plcur_pkg::op_e'(op_q);
  assign flags_o.head_null    = (head_q == NIL);
  assign flags_o.cur_null     = (cur_q == NIL);
  assign flags_o.full         = (used_q == NIL);
  assign flags_o.rd_match     = (rd_val_q == val_q);
  assign flags_o.rd_next_null = (rd_next_q == NIL);
  assign flags_o.link_null    = (link == NIL);
  assign flags_o.skip         = (f_q == cur_q) || (p_q == cur_q);
  assign flags_o.out_free     = !out_valid_q || !out_stall_i;

  // memory port selection
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = cur_q;
    val_we  = 1'b0;
    val_wa  = used_q;
    val_wd  = val_q;
    next_we = 1'b0;
    next_wa = used_q;
    next_wd = NIL;
    prev_we = 1'b0;
    prev_wa = used_q;
    prev_wd = tail_q;
    case (cmd_i)
      plcur_pkg::CMD_APPEND: begin
        val_we  = 1'b1;
        next_we = 1'b1;
        prev_we = 1'b1;
      end
      plcur_pkg::CMD_APP_TAIL: begin
        next_we = 1'b1;
        next_wa = aux_q;
        next_wd = f_q;
      end
      plcur_pkg::CMD_RD_CUR: rd_en = 1'b1;
      plcur_pkg::CMD_STEP_SEL: begin
        rd_en   = 1'b1;
        rd_addr = link;
      end
      plcur_pkg::CMD_SRCH_START: begin
        rd_en   = 1'b1;
        rd_addr = head_q;
      end
      plcur_pkg::CMD_SRCH_NEXT: begin
        rd_en   = 1'b1;
        rd_addr = rd_next_q;
      end
      plcur_pkg::CMD_UNLINK: begin
        // p != cursor here, so reading next[cursor] sees no conflict
        rd_en   = 1'b1;
        next_we = (p_q != NIL);
        next_wa = p_q;
        next_wd = q_q;
        prev_we = (q_q != NIL);
        prev_wa = q_q;
        prev_wd = p_q;
      end
      plcur_pkg::CMD_INS_RD: rd_en = 1'b1;
      plcur_pkg::CMD_LINK1: begin
        val_we  = new_q;
        val_wa  = f_q;
        next_we = 1'b1;
        next_wa = cur_q;
        next_wd = f_q;
        prev_we = 1'b1;
        prev_wa = f_q;
        prev_wd = cur_q;
      end
      plcur_pkg::CMD_LINK2: begin
        // rd_next_q still holds the old successor of the cursor
        next_we = 1'b1;
        next_wa = f_q;
        next_wd = rd_next_q;
        prev_we = (rd_next_q != NIL);
        prev_wa = rd_next_q;
        prev_wd = f_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (val_we) begin
      mem_val[val_wa[AW-1:0]] <= val_wd;
    end
    if (next_we) begin
      mem_next[next_wa[AW-1:0]] <= next_wd;
    end
    if (prev_we) begin
      mem_prev[prev_wa[AW-1:0]] <= prev_wd;
    end
    if (rd_en) begin
      rd_val_q  <= mem_val[rd_addr[AW-1:0]];
      rd_next_q <= mem_next[rd_addr[AW-1:0]];
      rd_prev_q <= mem_prev[rd_addr[AW-1:0]];
    end
  end

  // register next values
  always_comb begin
    head_d     = head_q;
    tail_d     = tail_q;
    cur_d      = cur_q;
    used_d     = used_q;
    op_d       = op_q;
    val_d      = val_q;
    curval_d   = curval_q;
    walk_d     = walk_q;
    f_d        = f_q;
    p_d        = p_q;
    q_d        = q_q;
    aux_d      = aux_q;
    new_d      = new_q;
    stat_d     = stat_q;
    out_val_d  = out_val_q;
    out_has_d  = out_has_q;
    out_stat_d = out_stat_q;
    out_valid_d = out_valid_q && out_stall_i;
    case (cmd_i)
      plcur_pkg::CMD_LOAD: begin
        op_d   = operation_i;
        val_d  = value_i;
        new_d  = 1'b0;
        stat_d = 1'b0;
      end
      plcur_pkg::CMD_FULL: stat_d = 1'b1;
      plcur_pkg::CMD_APPEND: begin
        f_d    = used_q;
        aux_d  = tail_q;
        tail_d = used_q;
        used_d = used_q + 1'b1;
        if (head_q == NIL) begin
          head_d   = used_q;
          cur_d    = used_q;
          curval_d = val_q;
        end
      end
      plcur_pkg::CMD_STEP_SEL:   walk_d = link;
      plcur_pkg::CMD_STEP_SET: begin
        cur_d    = walk_q;
        curval_d = rd_val_q;
      end
      plcur_pkg::CMD_SRCH_START: walk_d = head_q;
      plcur_pkg::CMD_SRCH_NEXT:  walk_d = rd_next_q;
      plcur_pkg::CMD_FOUND: begin
        f_d = walk_q;
        p_d = rd_prev_q;
        q_d = rd_next_q;
      end
      plcur_pkg::CMD_UNLINK: begin
        if (p_q == NIL) begin
          head_d = q_q;
        end
        if (q_q == NIL) begin
          tail_d = p_q;
        end
      end
      plcur_pkg::CMD_INS_RD: begin
        f_d   = used_q;
        new_d = 1'b1;
      end
      plcur_pkg::CMD_LINK1: begin
        if (new_q) begin
          used_d = used_q + 1'b1;
        end
      end
      plcur_pkg::CMD_LINK2: begin
        if (rd_next_q == NIL) begin
          tail_d = f_q;
        end
      end
      plcur_pkg::CMD_RESP: begin
        out_valid_d = 1'b1;
        out_val_d   = (cur_q == NIL) ? '0 : curval_q;
        out_has_d   = (cur_q != NIL);
        out_stat_d  = stat_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= NIL;
      tail_q      <= NIL;
      cur_q       <= NIL;
      used_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      head_q      <= head_d;
      tail_q      <= tail_d;
      cur_q       <= cur_d;
      used_q      <= used_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    val_q      <= val_d;
    curval_q   <= curval_d;
    walk_q     <= walk_d;
    f_q        <= f_d;
    p_q        <= p_d;
    q_q        <= q_d;
    aux_q      <= aux_d;
    new_q      <= new_d;
    stat_q     <= stat_d;
    out_val_q  <= out_val_d;
    out_has_q  <= out_has_d;
    out_stat_q <= out_stat_d;
  end

  assign out_valid_o     = out_valid_q;
  assign current_value_o = out_val_q;
  assign has_current_o   = out_has_q;
  assign status_o        = out_stat_q;

endmodule

// ===== hdl/playlist_list_with_cursor.sv =====
`timescale 1ns / 1ps
// Play-next searches the list from the head, one pool read per list node searched.
// Throughput: one request at a time; the search loop over the pool memory sets
//   the rate for play-next.
// Reset: head, tail and cursor go to the null marker, pool count to zero; pool
//   memories are not cleared, as nodes are handed out in order and read once written.
// ----------------------------------------------------------------------------
// playlist_list_with_cursor
// Doubly linked playlist in a node pool with a cursor and play-next moves.
// ----------------------------------------------------------------------------
module playlist_list_with_cursor #(
  parameter int NODES = plcur_pkg::NODES_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // request channel
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [plcur_pkg::OP_W-1:0]         operation_i,
  input  logic signed [plcur_pkg::VAL_W-1:0] value_i,
  // result channel
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic signed [plcur_pkg::VAL_W-1:0] current_value_o,
  output logic                               has_current_o,
  output logic                               status_o
);

  // The controller accepts a request only in its idle state, then steps the
  // datapath through micro-operations. The result register sits in the
  // datapath, so a finished result can wait on out_stall_i while the next
  // request is already taken in.
  plcur_pkg::cmd_e      cmd;
  plcur_pkg::dp_flags_t flags;

  plcur_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .flags_i    (flags),
    .cmd_o      (cmd)
  );

  // Datapath: value/next/prev pool memories with registered read ports,
  // head/tail/cursor/count registers, search and relink scratch registers.
  plcur_dp #(
    .NODES (NODES)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .operation_i     (operation_i),
    .value_i         (value_i),
    .cmd_i           (cmd),
    .flags_o         (flags),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .current_value_o (current_value_o),
    .has_current_o   (has_current_o),
    .status_o        (status_o)
  );

  // An accepted request must be latched by the datapath in that same cycle.
  a_accept_loads : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |-> (cmd == plcur_pkg::CMD_LOAD))
    else $error("accepted request not loaded");

  // A new result never overwrites one still held by a stall.
  a_no_overwrite : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd == plcur_pkg::CMD_RESP) |-> (!out_valid_o || !out_stall_i))
    else $error("result register overwritten while stalled");

  // Fresh nodes are only taken while the pool has room.
  a_no_alloc_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd == plcur_pkg::CMD_APPEND || cmd == plcur_pkg::CMD_INS_RD) |-> !flags.full)
    else $error("node taken from a full pool");

  // Once the list holds a node, the cursor stays valid.
  a_cursor_kept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !flags.cur_null |=> !flags.cur_null)
    else $error("cursor lost");

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the playlist list with cursor. A short table of
// requests walks the empty list, the ends of the list, head and tail moves
// and the unknown opcodes. Random traffic follows, mostly play-next moves
// of songs already in the list and cursor steps, with a trickle of inserts
// so that the pool fills up late in the run. Every result is checked
// against an in-bench model of the linked list.
// ----------------------------------------------------------------------------
module testbench;

  localparam int POOL_N = plcur_pkg::NODES_DEF;
  localparam int SLOT_W = $clog2(POOL_N + 1);
  localparam int RAND_PER_PHASE = 500;
  localparam int GAP_CAP = 40;
  localparam int DIR_N = 25;

  // Opcodes the block does not define; they must leave the list untouched.
  localparam logic [plcur_pkg::OP_W-1:0] OP_UNKNOWN_LO = 3'd5;
  localparam logic [plcur_pkg::OP_W-1:0] OP_UNKNOWN_HI = 3'd7;

  localparam logic signed [plcur_pkg::VAL_W-1:0] SONG_MIN = 32'sh8000_0000;
  localparam logic signed [plcur_pkg::VAL_W-1:0] SONG_MAX = 32'sh7FFF_FFFF;

  typedef logic [SLOT_W-1:0] slot_t;
  localparam slot_t NIL = slot_t'(POOL_N);

  typedef struct packed {
    logic signed [plcur_pkg::VAL_W-1:0] cur;
    logic                               has;
    logic                               status;
  } song_result_t;

  typedef struct packed {
    logic [plcur_pkg::OP_W-1:0]         op;
    logic signed [plcur_pkg::VAL_W-1:0] val;
    logic                               typed;   // 1: want holds the result to expect
    song_result_t                       want;
  } dir_row_t;

  localparam song_result_t NO_SONG = '{32'sd0, 1'b0, 1'b0};
  localparam song_result_t AT_MIN  = '{SONG_MIN, 1'b1, 1'b0};
  localparam song_result_t AT_MAX  = '{SONG_MAX, 1'b1, 1'b0};
  localparam song_result_t AT_ZERO = '{32'sd0, 1'b1, 1'b0};

  // Directed walk. Comments give the list order and the cursor (in []).
  dir_row_t dir_rows [DIR_N] = '{
    '{plcur_pkg::OP_READ,   32'sd0,   1'b1, NO_SONG},  // empty list
    '{plcur_pkg::OP_NEXT,   32'sd0,   1'b1, NO_SONG},  // step on empty list
    '{plcur_pkg::OP_PREV,   32'sd0,   1'b1, NO_SONG},
    '{OP_UNKNOWN_LO,        32'sd0,   1'b1, NO_SONG},
    '{plcur_pkg::OP_PLAY,   SONG_MIN, 1'b1, AT_MIN},   // play on empty acts as append: [MIN]
    '{plcur_pkg::OP_APPEND, SONG_MAX, 1'b1, AT_MIN},   // [MIN] MAX
    '{plcur_pkg::OP_APPEND, 32'sd0,   1'b1, AT_MIN},   // [MIN] MAX 0
    '{plcur_pkg::OP_PREV,   32'sd0,   1'b1, AT_MIN},   // off the head: stays
    '{plcur_pkg::OP_NEXT,   32'sd0,   1'b1, AT_MAX},
    '{plcur_pkg::OP_NEXT,   32'sd0,   1'b1, AT_ZERO},
    '{plcur_pkg::OP_NEXT,   32'sd0,   1'b1, AT_ZERO},  // off the tail: stays
    '{plcur_pkg::OP_PLAY,   32'sd0,   1'b0, NO_SONG},  // play the cursor song: no change
    '{plcur_pkg::OP_PREV,   32'sd0,   1'b0, NO_SONG},  // MIN [MAX] 0
    '{plcur_pkg::OP_PLAY,   32'sd0,   1'b0, NO_SONG},  // already next: no change
    '{plcur_pkg::OP_PREV,   32'sd0,   1'b0, NO_SONG},  // [MIN] MAX 0
    '{plcur_pkg::OP_PLAY,   32'sd0,   1'b0, NO_SONG},  // tail moves: [MIN] 0 MAX
    '{plcur_pkg::OP_PLAY,   SONG_MAX, 1'b0, NO_SONG},  // tail moves back: [MIN] MAX 0
    '{plcur_pkg::OP_NEXT,   32'sd0,   1'b0, NO_SONG},
    '{plcur_pkg::OP_NEXT,   32'sd0,   1'b0, NO_SONG},  // MIN MAX [0]
    '{plcur_pkg::OP_PLAY,   SONG_MIN, 1'b0, NO_SONG},  // head moves behind the tail
    '{plcur_pkg::OP_NEXT,   32'sd0,   1'b0, NO_SONG},  // MAX 0 [MIN]
    '{plcur_pkg::OP_PLAY,   32'sd1,   1'b0, NO_SONG},  // new song inserted as tail
    '{plcur_pkg::OP_NEXT,   32'sd0,   1'b0, NO_SONG},
    '{plcur_pkg::OP_APPEND, SONG_MIN, 1'b0, NO_SONG},  // duplicate song value
    '{OP_UNKNOWN_HI,        -32'sd1,  1'b0, NO_SONG}
  };

  logic                               clk_i = 1'b0;
  logic                               rst_ni = 1'b0;
  logic                               in_valid_i = 1'b0;
  logic                               in_stall_o;
  logic [plcur_pkg::OP_W-1:0]         operation_i = plcur_pkg::OP_READ;
  logic signed [plcur_pkg::VAL_W-1:0] value_i = '0;
  logic                               out_valid_o;
  logic                               out_stall_i = 1'b0;
  logic signed [plcur_pkg::VAL_W-1:0] current_value_o;
  logic                               has_current_o;
  logic                               status_o;

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned mismatch_count = 0;

  song_result_t cursor_report_q[$];

  playlist_list_with_cursor #(.NODES(POOL_N)) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .operation_i    (operation_i),
    .value_i        (value_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .current_value_o(current_value_o),
    .has_current_o  (has_current_o),
    .status_o       (status_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Playlist model: pool of song slots with forward and backward links.
  // Slots are handed out in order and never returned, NIL marks no slot.
  // --------------------------------------------------------------------------
  logic signed [plcur_pkg::VAL_W-1:0] song_at   [POOL_N];
  slot_t                              fwd_link  [POOL_N];
  slot_t                              back_link [POOL_N];
  slot_t                              head_slot = NIL;
  slot_t                              tail_slot = NIL;
  slot_t                              cursor_slot = NIL;
  int unsigned                        pool_used = 0;

  function automatic bit is_slot(slot_t s);
    return s < POOL_N;
  endfunction

  // Returns NIL once the pool is exhausted.
  function automatic slot_t grab_slot(logic signed [plcur_pkg::VAL_W-1:0] v);
    slot_t s;
    if (pool_used >= POOL_N) return NIL;
    s = slot_t'(pool_used);
    pool_used++;
    song_at[s]   = v;
    fwd_link[s]  = NIL;
    back_link[s] = NIL;
    return s;
  endfunction

  // First slot ever linked also becomes head and cursor.
  function automatic void link_tail(slot_t s);
    if (!is_slot(head_slot)) begin
      head_slot   = s;
      tail_slot   = s;
      cursor_slot = s;
      return;
    end
    if (is_slot(tail_slot)) fwd_link[tail_slot] = s;
    back_link[s] = tail_slot;
    fwd_link[s]  = NIL;
    tail_slot    = s;
  endfunction

  function automatic void splice_after(slot_t c, slot_t s);
    slot_t after;
    after        = fwd_link[c];
    fwd_link[c]  = s;
    back_link[s] = c;
    fwd_link[s]  = after;
    if (is_slot(after)) back_link[after] = s;
    else                tail_slot = s;
  endfunction

  function automatic void cut_out(slot_t s);
    slot_t p, q;
    p = back_link[s];
    q = fwd_link[s];
    if (is_slot(p)) fwd_link[p] = q;
    else            head_slot = q;
    if (is_slot(q)) back_link[q] = p;
    else            tail_slot = p;
  endfunction

  // Applies one request to the model and returns what the cursor reports.
  function automatic song_result_t playlist_step(logic [plcur_pkg::OP_W-1:0] op,
                                                 logic signed [plcur_pkg::VAL_W-1:0] v);
    song_result_t res;
    slot_t        s, walk, hit;
    int unsigned  steps;
    res = NO_SONG;
    case (op)
      plcur_pkg::OP_APPEND: begin
        s = grab_slot(v);
        if (is_slot(s)) link_tail(s);
        else            res.status = 1'b1;
      end
      plcur_pkg::OP_NEXT: begin
        if (is_slot(cursor_slot) && is_slot(fwd_link[cursor_slot]))
          cursor_slot = fwd_link[cursor_slot];
      end
      plcur_pkg::OP_PREV: begin
        if (is_slot(cursor_slot) && is_slot(back_link[cursor_slot]))
          cursor_slot = back_link[cursor_slot];
      end
      plcur_pkg::OP_PLAY: begin
        if (!is_slot(cursor_slot)) begin
          s = grab_slot(v);
          if (is_slot(s)) link_tail(s);
          else            res.status = 1'b1;
        end else begin
          // First match from the head wins.
          hit   = NIL;
          walk  = head_slot;
          steps = 0;
          while (is_slot(walk) && steps < POOL_N) begin
            if (song_at[walk] == v) begin
              hit = walk;
              break;
            end
            walk = fwd_link[walk];
            steps++;
          end
          if (is_slot(hit)) begin
            if (hit != cursor_slot && back_link[hit] != cursor_slot) begin
              cut_out(hit);
              splice_after(cursor_slot, hit);
            end
          end else begin
            s = grab_slot(v);
            if (is_slot(s)) splice_after(cursor_slot, s);
            else            res.status = 1'b1;
          end
        end
      end
      default: ;
    endcase
    if (is_slot(cursor_slot)) begin
      res.cur = song_at[cursor_slot];
      res.has = 1'b1;
    end
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Request side. Called right after the previous acceptance edge; valid
  // either stays high with a new payload or drops for a random gap.
  // --------------------------------------------------------------------------
  task automatic send_request(input logic [plcur_pkg::OP_W-1:0] op,
                              input logic signed [plcur_pkg::VAL_W-1:0] v,
                              input logic use_given,
                              input song_result_t given);
    int unsigned  gap;
    song_result_t predicted;
    gap = 0;
    while (gap < GAP_CAP && $urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    operation_i <= op;
    value_i     <= v;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    // Accepted at this edge.
    predicted = playlist_step(op, v);
    cursor_report_q.push_back(use_given ? given : predicted);
  endtask

  // Random mix: mostly moves of songs already queued and cursor steps.
  // Inserts are kept rare so the pool only runs out late in the run.
  task automatic random_request();
    int unsigned                        r;
    int unsigned                        pick;
    logic [plcur_pkg::OP_W-1:0]         op;
    logic signed [plcur_pkg::VAL_W-1:0] v;
    logic signed [plcur_pkg::VAL_W-1:0] known;
    r     = $urandom_range(99);
    pick  = $urandom_range(OP_UNKNOWN_LO, OP_UNKNOWN_HI);
    v     = $urandom();
    known = (pool_used > 0) ? song_at[$urandom_range(pool_used - 1)] : v;
    if      (r < 2)  op = plcur_pkg::OP_APPEND;
    else if (r < 3)  begin op = plcur_pkg::OP_APPEND; v = known; end
    else if (r < 5)  op = plcur_pkg::OP_PLAY;
    else if (r < 40) begin op = plcur_pkg::OP_PLAY; v = known; end
    else if (r < 62) op = plcur_pkg::OP_NEXT;
    else if (r < 84) op = plcur_pkg::OP_PREV;
    else if (r < 94) op = plcur_pkg::OP_READ;
    else             op = pick[plcur_pkg::OP_W-1:0];
    send_request(op, v, 1'b0, NO_SONG);
  endtask

  // Result side: random stall, driven at the edge.
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_idle_pct);
  end

  // Compare every accepted result with the oldest expectation.
  always @(posedge clk_i) begin : result_check
    song_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (cursor_report_q.size() == 0) begin
        $error("result with nothing expected: current_value %0d", current_value_o);
        mismatch_count++;
      end else begin
        want = cursor_report_q.pop_front();
        if (current_value_o !== want.cur) begin
          $error("current_value: expected %0d, got %0d", want.cur, current_value_o);
          mismatch_count++;
        end
        if (has_current_o !== want.has) begin
          $error("has_current: expected %0d, got %0d", want.has, has_current_o);
          mismatch_count++;
        end
        if (status_o !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status_o);
          mismatch_count++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence: three idle profiles, directed table in the first one.
  // --------------------------------------------------------------------------
  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0:       begin send_idle_pct = 26; recv_idle_pct = 57; end
        1:       begin send_idle_pct = 57; recv_idle_pct = 26; end
        default: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
      endcase
      if (phase == 0) begin
        for (int i = 0; i < DIR_N; i++)
          send_request(dir_rows[i].op, dir_rows[i].val, dir_rows[i].typed,
                       dir_rows[i].want);
      end
      repeat (RAND_PER_PHASE) random_request();
    end
    in_valid_i <= 1'b0;

    // Drain, then allow a search's worth of cycles for anything stray.
    while (cursor_report_q.size() != 0) @(posedge clk_i);
    repeat (POOL_N + 20) @(posedge clk_i);

    if (mismatch_count == 0) $display("SCOREBOARD CLEAN");
    else                     $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #20ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
